// ----- src/i2c_master_bit_sequencer_macros.svh -----
// Assertion macros used by the checker file of the line sequencer.
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define I2CBS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("I2C sequencer check failed");

// Checks a property on every rising clock edge, reset included.
`define I2CBS_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("I2C sequencer check failed during or after reset");

`endif

// ----- src/i2cbs_pkg.sv -----
// Package with the word types, command codes and sizes of the I2C line sequencer.
package i2cbs_pkg;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4,
		CMD_WACK  = 3'd5,
		CMD_ACK   = 3'd6,
		CMD_NACK  = 3'd7
	} cmd_t;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [3:0] LAST_BIT_SLOT = 4'd15;
	localparam logic [3:0] ACK_SAMPLE_SLOT = 4'd1;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] data;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_seen;
	} rsp_t;

endpackage

// ----- src/i2cbs_front.sv -----
// Slot engine: takes one slot word, advances the command state and forms its result word.
module i2cbs_front
	import i2cbs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t req,
	output rsp_t rsp
);

	logic       scl_level_q;
	logic       sda_level_q;
	cmd_t       cmd_q;
	logic [3:0] slot_q;
	logic [7:0] shift_q;
	logic       ack_q;
	logic [7:0] rdata_q;

	cmd_t       cmd_d;
	logic [3:0] slot_d;
	logic [7:0] shift_d;
	logic       ack_d;
	logic [7:0] rdata_d;
	logic       scl_d;
	logic       sda_d;
	logic       scl_level_d;
	logic       sda_level_d;
	logic       done;
	logic       hold_low;
	cmd_t       eff_cmd;
	logic [3:0] slot;
	logic [7:0] shift_ld;

	always_comb begin
		eff_cmd = cmd_q;
		slot = slot_q;
		shift_ld = shift_q;
		ack_d = ack_q;
		if (cmd_q == CMD_NONE && cmd_t'(req.req_type) != CMD_NONE) begin
			eff_cmd = cmd_t'(req.req_type);
			slot = '0;
			if (eff_cmd == CMD_WRITE) begin
				shift_ld = req.data;
			end
			if (eff_cmd == CMD_READ) begin
				shift_ld = '0;
			end
			if (eff_cmd == CMD_WACK) begin
				ack_d = 1'b1;
			end
		end
		shift_d = shift_ld;
		rdata_d = rdata_q;
		scl_d = scl_level_q;
		sda_d = sda_level_q;
		done = 1'b0;
		hold_low = 1'b0;
		case (eff_cmd)
			CMD_START: begin
				scl_d = 1'b1;
				sda_d = (slot == '0);
				if (slot != '0) begin
					done = 1'b1;
					hold_low = 1'b1;
				end
			end
			CMD_STOP: begin
				scl_d = 1'b1;
				sda_d = (slot != '0);
				done = (slot != '0);
			end
			CMD_WRITE: begin
				sda_d = shift_ld[7];
				scl_d = ~slot[0];
				if (slot[0]) begin
					shift_d = {shift_ld[6:0], 1'b0};
				end
				done = (slot == LAST_BIT_SLOT);
			end
			CMD_READ: begin
				sda_d = 1'b1;
				scl_d = ~slot[0];
				if (!slot[0]) begin
					shift_d = {shift_ld[6:0], req.sda_in};
				end
				if (slot == LAST_BIT_SLOT) begin
					done = 1'b1;
					rdata_d = shift_ld;
				end
			end
			CMD_WACK, CMD_ACK, CMD_NACK: begin
				sda_d = (eff_cmd != CMD_ACK);
				if (slot == ACK_SAMPLE_SLOT) begin
					scl_d = 1'b1;
					if (eff_cmd == CMD_WACK) begin
						ack_d = req.sda_in;
					end
				end else if (slot > ACK_SAMPLE_SLOT) begin
					scl_d = 1'b0;
					done = 1'b1;
				end
			end
			default: begin
			end
		endcase
		scl_level_d = scl_level_q;
		sda_level_d = sda_level_q;
		cmd_d = eff_cmd;
		slot_d = slot;
		if (eff_cmd != CMD_NONE) begin
			scl_level_d = hold_low ? 1'b0 : scl_d;
			sda_level_d = sda_d;
			if (done) begin
				cmd_d = CMD_NONE;
				slot_d = '0;
			end else begin
				slot_d = slot + 4'd1;
			end
		end
		rsp.scl = scl_d;
		rsp.sda_out = sda_d;
		rsp.busy_res = (eff_cmd != CMD_NONE);
		rsp.done_res = done;
		rsp.read_data = rdata_d;
		rsp.ack_seen = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_level_q <= 1'b1;
			sda_level_q <= 1'b1;
			cmd_q <= CMD_NONE;
			slot_q <= '0;
			shift_q <= '0;
			ack_q <= 1'b1;
			rdata_q <= '0;
		end else if (push) begin
			scl_level_q <= scl_level_d;
			sda_level_q <= sda_level_d;
			cmd_q <= cmd_d;
			slot_q <= slot_d;
			shift_q <= shift_d;
			ack_q <= ack_d;
			rdata_q <= rdata_d;
		end
	end

endmodule

// ----- src/i2cbs_queue.sv -----
// Result queue that holds finished slot words until the consumer takes them.
module i2cbs_queue
	import i2cbs_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rsp_t push_word,
	output logic full,
	output logic pop_valid,
	input  logic pop_ready,
	output rsp_t pop_word
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	rsp_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign full = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop = pop_valid && pop_ready;
	assign pop_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- src/i2c_master_bit_sequencer.sv -----
// Top level of the I2C master line sequencer: slot engine followed by a result queue.
//   channel | direction | handshake              | word
//   req     | in        | req_valid / req_ready  | req_type, data, sda_in
//   rsp     | out       | rsp_valid / rsp_ready  | scl, sda_out, busy_res, done_res,
//           |           |                        | read_data, ack_seen
// One slot word is accepted per cycle while the queue is not full; its result word is queued for rsp.
// The slot engine updates its command state in the cycle a word is accepted.
// Results wait in a DEPTH-entry queue; req_ready is low only while that queue is full.
// Reset is asynchronous and returns the bus levels high with no command active.
module i2c_master_bit_sequencer
	import i2cbs_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic push;
	logic full;
	rsp_t slot_word;

	assign req_ready = ~full;
	assign push = req_valid && req_ready;

	i2cbs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.req    (req),
		.rsp    (slot_word)
	);

	i2cbs_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (slot_word),
		.full      (full),
		.pop_valid (rsp_valid),
		.pop_ready (rsp_ready),
		.pop_word  (rsp)
	);

endmodule

// ----- src/i2cbs_checker.sv -----
// Port checker for the I2C line sequencer and its bind to the top level.
`include "i2c_master_bit_sequencer_macros.svh"

module i2cbs_checker
	import i2cbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	`I2CBS_ASSERT(a_req_hold, clk, arst_n, req_valid && !req_ready |=> req_valid && $stable(req))
	`I2CBS_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
	`I2CBS_ASSERT(a_done_busy, clk, arst_n, rsp_valid && rsp.done_res |-> rsp.busy_res)
	`I2CBS_ASSERT_ALWAYS(a_empty_ready, clk, !rsp_valid |-> req_ready)

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_checker (.*);
